/* design/ilha_pkg.sv */
`timescale 1ns / 1ps
package ilha_pkg;

   localparam int unsigned OFF_W    = 17;
   localparam int unsigned CFG_W    = 17;
   localparam int unsigned REQ_W    = 32;
   localparam int unsigned RSP_W    = 40;
   localparam int unsigned FUNC_W   = 2;

   localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_FREE    = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_REALLOC = 2'd2;

   localparam logic [OFF_W-1:0] FIRST_PAYLOAD = 17'd16;
   localparam logic [OFF_W-1:0] INITIAL_CHUNK = 17'd4096;
   localparam logic [OFF_W-1:0] MIN_BLOCK     = 17'd16;
   localparam logic [OFF_W-1:0] TAG_BYTES     = 17'd8;
   localparam logic [OFF_W-1:0] CHUNK_RESET   = 17'd4096;
   localparam logic [31:0]      PROLOGUE_TAG  = 32'd9;
   localparam logic [31:0]      EPILOGUE_TAG  = 32'd1;

   function automatic logic [31:0] make_tag(input logic [OFF_W-1:0] sz, input logic used);
      make_tag = {15'd0, sz[OFF_W-1:1], used};
   endfunction

endpackage

/* design/implicit_list_heap_allocator.sv */
`timescale 1ns / 1ps
// Boundary-tag heap allocator with first-fit search over an implicit block list.
// req channel: one request per handshake; req_tuser carries the operation
// (allocate, free, reallocate), req_tdata the size and the block payload offset.
// rsp channel: exactly one response per request with the resulting address, the
// success flag and, after a relocation, the number of payload bytes to copy.
// csr channel: writes the minimum heap extension in bytes; always ready. The user
// must write it only while no request is in flight; the block does not enforce it.
// Every tag access goes through the single tag memory, one read or one write per
// cycle. The list walk reads the header of each block visited before the fit or
// the target block and then checks it; a claim takes 2 writes, a split adds 2
// writes, a merge 2 reads and 2 writes, an extension 3 writes. One request is
// handled at a time.
// Reset: after reset is released an init pass writes the prologue, one free
// 4096-byte block and the epilogue; req_tready stays low meanwhile.
// A response waits in the output register while rsp_tready is low; the block may
// take the next request and holds in its done state until the response is taken.
module implicit_list_heap_allocator #(
   parameter int unsigned HEAP_BYTES = 65536
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [ilha_pkg::REQ_W-1:0]  req_tdata,   // req_size[15:0], block_addr[31:16]
   input  logic [ilha_pkg::FUNC_W-1:0] req_tuser,   // func[1:0]
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [ilha_pkg::RSP_W-1:0]  rsp_tdata,   // result_addr[15:0], ok[16],
                                                    // copy_len[32:17], zero[39:33]
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [ilha_pkg::CFG_W-1:0]  csr_data
);
   import ilha_pkg::*;

   localparam int unsigned HEAP_CAP  = (HEAP_BYTES < 65536) ? HEAP_BYTES : 65536;
   localparam int unsigned HEAP_LIMIT = HEAP_CAP & ~7;
   localparam int unsigned MEM_WORDS = HEAP_LIMIT / 4;
   localparam int unsigned AW        = $clog2(MEM_WORDS);
   localparam logic [OFF_W:0] LIMIT18 = (OFF_W+1)'(HEAP_LIMIT);

   typedef enum logic [4:0] {
      ST_INIT, ST_IDLE, ST_WALK_RD, ST_WALK_CHK, ST_MISS, ST_GROW, ST_GROW_W1,
      ST_GROW_W2, ST_CL_W0, ST_CL_W1, ST_CL_W2, ST_CL_W3, ST_FINISH, ST_FREE_W0,
      ST_FREE_W1, ST_MG_RDP, ST_MG_RDN, ST_MG_CALC, ST_MG_W0, ST_MG_W1,
      ST_NXT_RD, ST_NXT_CHK, ST_DONE
   } state_type;

   function automatic logic [AW-1:0] widx(input logic [OFF_W-1:0] off);
      widx = off[AW+1:2];
   endfunction

   logic [31:0] mem [MEM_WORDS];
   logic [31:0] rdata_ff;
   logic          mem_we;
   logic [AW-1:0] mem_wa, mem_ra;
   logic [31:0]   mem_wd;

   state_type         state_ff, state_in;
   logic [2:0]        init_cnt_ff, init_cnt_in;
   logic [OFF_W-1:0]  brk_ff, brk_in, chunk_ff, chunk_in;
   logic [FUNC_W-1:0] func_ff, func_in;
   logic              reqz_ff, reqz_in, live_ff, live_in, reloc_ff, reloc_in;
   logic              pend_ff, pend_in, pfree_ff, pfree_in;
   logic [15:0]       addr_ff, addr_in;
   logic [OFF_W-1:0]  need_ff, need_in, bp_ff, bp_in, sz_ff, sz_in, old_ff, old_in;
   logic [OFF_W-1:0]  m_ff, m_in, msz_ff, msz_in, psz_ff, psz_in;
   logic [OFF_W-1:0]  base_ff, base_in, total_ff, total_in;
   logic [15:0]       res_ff, res_in, copy_ff, copy_in;
   logic              ok_ff, ok_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]  rsp_data_ff, rsp_data_in;

   logic [OFF_W-1:0]  rd_sz, rem, addr17, want, blk_sz;
   logic              rd_used, split;
   logic [OFF_W:0]    w18, gsz18;
   logic [OFF_W-1:0]  r7;

   assign rd_sz   = {rdata_ff[16:3], 3'b000};
   assign rd_used = rdata_ff[0];
   assign rem     = sz_ff - need_ff;
   assign split   = rem >= MIN_BLOCK;
   assign blk_sz  = split ? need_ff : sz_ff;
   assign addr17  = {1'b0, addr_ff};
   assign want    = (need_ff > chunk_ff) ? need_ff : chunk_ff;
   assign w18     = {1'b0, want[OFF_W-1:2], 2'b00} + (OFF_W+1)'(7);
   assign gsz18   = {w18[OFF_W:3], 3'b000};
   assign r7      = {1'b0, req_tdata[15:0]} + OFF_W'(7);

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

   always_comb begin
      state_in = state_ff;   init_cnt_in = init_cnt_ff; brk_in = brk_ff;
      chunk_in = csr_valid ? csr_data : chunk_ff;
      func_in = func_ff;     reqz_in = reqz_ff;   live_in = live_ff;  reloc_in = reloc_ff;
      pend_in = pend_ff;     pfree_in = pfree_ff; addr_in = addr_ff;  need_in = need_ff;
      bp_in = bp_ff;         sz_in = sz_ff;       old_in = old_ff;    m_in = m_ff;
      msz_in = msz_ff;       psz_in = psz_ff;     base_in = base_ff;  total_in = total_ff;
      res_in = res_ff;       copy_in = copy_ff;   ok_in = ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      mem_we = 1'b0; mem_wa = '0; mem_wd = '0; mem_ra = '0;

      unique case (state_ff)
         ST_INIT: begin
            mem_we = 1'b1;
            init_cnt_in = init_cnt_ff + 3'd1;
            unique case (init_cnt_ff)
               3'd0: begin mem_wa = widx(OFF_W'(4)); mem_wd = PROLOGUE_TAG; end
               3'd1: begin mem_wa = widx(OFF_W'(8)); mem_wd = PROLOGUE_TAG; end
               3'd2: begin
                  mem_wa = widx(FIRST_PAYLOAD - OFF_W'(4));
                  mem_wd = make_tag(INITIAL_CHUNK, 1'b0);
               end
               3'd3: begin
                  mem_wa = widx(FIRST_PAYLOAD + INITIAL_CHUNK - TAG_BYTES);
                  mem_wd = make_tag(INITIAL_CHUNK, 1'b0);
               end
               default: begin
                  mem_wa = widx(FIRST_PAYLOAD + INITIAL_CHUNK - OFF_W'(4));
                  mem_wd = EPILOGUE_TAG;
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               func_in  = req_tuser;
               addr_in  = req_tdata[31:16];
               reqz_in  = (req_tdata[15:0] == 16'd0);
               need_in  = {r7[OFF_W-1:3], 3'b000} + TAG_BYTES;
               reloc_in = 1'b0;
               pend_in  = 1'b0;
               bp_in    = FIRST_PAYLOAD;
               res_in = 16'd0; ok_in = 1'b0; copy_in = 16'd0;
               unique case (req_tuser)
                  FUNC_ALLOC: begin
                     live_in = 1'b0;
                     if (req_tdata[15:0] == 16'd0) begin
                        ok_in = 1'b1; state_in = ST_DONE;
                     end else begin
                        state_in = ST_WALK_RD;
                     end
                  end
                  FUNC_FREE: begin
                     live_in = 1'b1;
                     if (req_tdata[31:16] == 16'd0) begin
                        ok_in = 1'b1; state_in = ST_DONE;
                     end else begin
                        state_in = ST_WALK_RD;
                     end
                  end
                  FUNC_REALLOC: begin
                     priority if (req_tdata[31:16] != 16'd0) begin
                        live_in = 1'b1; state_in = ST_WALK_RD;
                     end else if (req_tdata[15:0] == 16'd0) begin
                        ok_in = 1'b1; state_in = ST_DONE;
                     end else begin
                        live_in = 1'b0; state_in = ST_WALK_RD;
                     end
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_WALK_RD: begin
            if (bp_ff >= brk_ff) begin
               state_in = ST_MISS;
            end else begin
               mem_ra = widx(bp_ff - OFF_W'(4));
               state_in = ST_WALK_CHK;
            end
         end
         ST_WALK_CHK: begin
            if (live_ff) begin
               priority if (rd_sz == '0 || bp_ff > addr17) begin
                  state_in = ST_MISS;
               end else if (bp_ff == addr17) begin
                  if (!rd_used) begin
                     state_in = ST_MISS;
                  end else begin
                     old_in = rd_sz;
                     if (func_ff == FUNC_FREE || reqz_ff) begin
                        m_in = addr17; msz_in = rd_sz;
                        ok_in = 1'b1;
                        state_in = ST_FREE_W0;
                     end else begin
                        state_in = ST_NXT_RD;
                     end
                  end
               end else begin
                  bp_in = bp_ff + rd_sz; state_in = ST_WALK_RD;
               end
            end else begin
               priority if (rd_sz == '0) begin
                  state_in = ST_MISS;
               end else if (!rd_used && rd_sz >= need_ff) begin
                  sz_in = rd_sz; state_in = ST_CL_W0;
               end else begin
                  bp_in = bp_ff + rd_sz; state_in = ST_WALK_RD;
               end
            end
         end
         ST_MISS: begin
            // unknown block answers a plain failure; a failed fit extends the heap
            state_in = live_ff ? ST_DONE : ST_GROW;
         end
         ST_GROW: begin
            if (gsz18 < (OFF_W+1)'(MIN_BLOCK) || {1'b0, brk_ff} > LIMIT18 ||
                gsz18 > LIMIT18 - {1'b0, brk_ff}) begin
               state_in = ST_DONE;
            end else begin
               mem_we = 1'b1;
               mem_wa = widx(brk_ff - OFF_W'(4));
               mem_wd = make_tag(gsz18[OFF_W-1:0], 1'b0);
               bp_in  = brk_ff;
               sz_in  = gsz18[OFF_W-1:0];
               state_in = ST_GROW_W1;
            end
         end
         ST_GROW_W1: begin
            mem_we = 1'b1;
            mem_wa = widx(bp_ff + sz_ff - TAG_BYTES);
            mem_wd = make_tag(sz_ff, 1'b0);
            state_in = ST_GROW_W2;
         end
         ST_GROW_W2: begin
            mem_we = 1'b1;
            mem_wa = widx(bp_ff + sz_ff - OFF_W'(4));
            mem_wd = EPILOGUE_TAG;
            brk_in = bp_ff + sz_ff;
            state_in = ST_CL_W0;
         end
         ST_CL_W0: begin
            mem_we = 1'b1;
            mem_wa = widx(bp_ff - OFF_W'(4));
            mem_wd = make_tag(blk_sz, 1'b1);
            res_in  = bp_ff[15:0];
            ok_in   = 1'b1;
            copy_in = reloc_ff ? 16'(old_ff - TAG_BYTES) : 16'd0;
            pend_in = reloc_ff;
            state_in = ST_CL_W1;
         end
         ST_CL_W1: begin
            mem_we = 1'b1;
            mem_wa = widx(bp_ff + blk_sz - TAG_BYTES);
            mem_wd = make_tag(blk_sz, 1'b1);
            state_in = split ? ST_CL_W2 : ST_FINISH;
         end
         ST_CL_W2: begin
            mem_we = 1'b1;
            mem_wa = widx(bp_ff + need_ff - OFF_W'(4));
            mem_wd = make_tag(rem, 1'b0);
            state_in = ST_CL_W3;
         end
         ST_CL_W3: begin
            mem_we = 1'b1;
            mem_wa = widx(bp_ff + sz_ff - TAG_BYTES);
            mem_wd = make_tag(rem, 1'b0);
            m_in   = bp_ff + need_ff;
            msz_in = rem;
            state_in = ST_MG_RDP;
         end
         ST_FINISH: begin
            // a relocation frees the old block only after the new one is taken
            if (pend_ff) begin
               pend_in = 1'b0;
               m_in = addr17; msz_in = old_ff;
               state_in = ST_FREE_W0;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_FREE_W0: begin
            mem_we = 1'b1;
            mem_wa = widx(m_ff - OFF_W'(4));
            mem_wd = make_tag(msz_ff, 1'b0);
            state_in = ST_FREE_W1;
         end
         ST_FREE_W1: begin
            mem_we = 1'b1;
            mem_wa = widx(m_ff + msz_ff - TAG_BYTES);
            mem_wd = make_tag(msz_ff, 1'b0);
            state_in = ST_MG_RDP;
         end
         ST_MG_RDP: begin
            mem_ra = widx(m_ff - TAG_BYTES);
            state_in = ST_MG_RDN;
         end
         ST_MG_RDN: begin
            psz_in   = rd_sz;
            pfree_in = !rd_used;
            mem_ra   = widx(m_ff + msz_ff - OFF_W'(4));
            state_in = ST_MG_CALC;
         end
         ST_MG_CALC: begin
            if (!pfree_ff && rd_used) begin
               state_in = ST_FINISH;
            end else begin
               base_in  = pfree_ff ? m_ff - psz_ff : m_ff;
               total_in = msz_ff + (pfree_ff ? psz_ff : '0) + (rd_used ? '0 : rd_sz);
               state_in = ST_MG_W0;
            end
         end
         ST_MG_W0: begin
            mem_we = 1'b1;
            mem_wa = widx(base_ff - OFF_W'(4));
            mem_wd = make_tag(total_ff, 1'b0);
            state_in = ST_MG_W1;
         end
         ST_MG_W1: begin
            mem_we = 1'b1;
            mem_wa = widx(base_ff + total_ff - TAG_BYTES);
            mem_wd = make_tag(total_ff, 1'b0);
            state_in = ST_FINISH;
         end
         ST_NXT_RD: begin
            mem_ra = widx(addr17 + old_ff - OFF_W'(4));
            state_in = ST_NXT_CHK;
         end
         ST_NXT_CHK: begin
            bp_in = addr17;
            priority if (need_ff <= old_ff) begin
               sz_in = old_ff; state_in = ST_CL_W0;
            end else if (!rd_used && need_ff <= old_ff + rd_sz) begin
               sz_in = old_ff + rd_sz; state_in = ST_CL_W0;
            end else begin
               reloc_in = 1'b1;
               live_in  = 1'b0;
               bp_in    = FIRST_PAYLOAD;
               state_in = ST_WALK_RD;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {7'd0, copy_ff, ok_ff, res_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rdata_ff <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         init_cnt_ff  <= 3'd0;
         brk_ff       <= FIRST_PAYLOAD + INITIAL_CHUNK;
         chunk_ff     <= CHUNK_RESET;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         reloc_ff     <= 1'b0;
         live_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_cnt_ff  <= init_cnt_in;
         brk_ff       <= brk_in;
         chunk_ff     <= chunk_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         reloc_ff     <= reloc_in;
         live_ff      <= live_in;
      end
      func_ff <= func_in;   reqz_ff <= reqz_in;   pfree_ff <= pfree_in;
      addr_ff <= addr_in;   need_ff <= need_in;   bp_ff <= bp_in;
      sz_ff <= sz_in;       old_ff <= old_in;     m_ff <= m_in;
      msz_ff <= msz_in;     psz_ff <= psz_in;     base_ff <= base_in;
      total_ff <= total_in; res_ff <= res_in;     copy_ff <= copy_in;
      ok_ff <= ok_in;       rsp_data_ff <= rsp_data_in;
   end

`ifndef ASSERT_OFF
   a_brk_align: assert property (@(posedge clock) disable iff (reset)
      brk_ff[2:0] == 3'd0) else $error("heap break not 8-byte aligned");

   a_brk_limit: assert property (@(posedge clock) disable iff (reset)
      {1'b0, brk_ff} <= LIMIT18) else $error("heap break beyond heap limit");

   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff[16] |-> rsp_data_ff[15:0] == 16'd0 &&
      rsp_data_ff[32:17] == 16'd0) else $error("failed response carries data");

   a_copy_reloc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[32:17] != 16'd0 |-> rsp_data_ff[15:0] != 16'd0 &&
      rsp_data_ff[2:0] == 3'd0) else $error("copy length without new block");
`endif

endmodule
